>>> hdl/smooth_quad_terrain_subdivide_assert.svh
// Assertion macros for the terrain subdivision block.
`ifndef SMOOTH_QUAD_TERRAIN_SUBDIVIDE_ASSERT_SVH
`define SMOOTH_QUAD_TERRAIN_SUBDIVIDE_ASSERT_SVH
`ifndef SYNTH
`define SQTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define SQTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SQTS_ASSERT_IMP(lbl, ante, cons)
`define SQTS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hdl/sqts_pkg.sv
// Shared types and constants for the terrain subdivision block.
`timescale 1ns / 1ps
package sqts_pkg;
  localparam int DIV_STEPS = 31;
  localparam logic [0:0] REG_MAX_HEIGHT = 1'd0;
  localparam logic [0:0] REG_ROUGHNESS = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_DIVEND,
    ST_NEXTCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       zero_off;
    logic       load_mul;
    logic       load_rough;
    logic       step;
    logic       store;
    logic       out_load;
    logic [1:0] child;
  } cmd_t;

  typedef struct packed {
    logic       mag_zero;
    logic       out_free;
    logic [4:0] level;
  } status_t;
endpackage

>>> hdl/sqts_ctrl.sv
// Sequencer for the terrain subdivision block.
`timescale 1ns / 1ps
`include "smooth_quad_terrain_subdivide_assert.svh"
module sqts_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  sqts_pkg::status_t status,
  output sqts_pkg::cmd_t    cmd
);
  import sqts_pkg::*;

  state_t     state, state_next;
  logic [4:0] step, step_next;
  logic [4:0] lvl, lvl_next;
  logic [1:0] child, child_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      lvl   <= '0;
      child <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      lvl   <= lvl_next;
      child <= child_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    lvl_next   = lvl;
    child_next = child;
    cmd        = '0;
    cmd.child  = child;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          child_next  = '0;
          state_next  = ST_START;
        end
      end
      ST_START: begin
        lvl_next  = '0;
        step_next = '0;
        if (status.mag_zero) begin
          cmd.zero_off = 1'b1;
          state_next   = ST_NEXTCH;
        end else begin
          cmd.load_mul = 1'b1;
          state_next   = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (step == 5'(DIV_STEPS - 1)) begin
          step_next  = '0;
          state_next = ST_DIVEND;
        end else begin
          step_next = step + 5'd1;
        end
      end
      ST_DIVEND: begin
        if (lvl == status.level) begin
          cmd.store  = 1'b1;
          state_next = ST_NEXTCH;
        end else begin
          cmd.load_rough = 1'b1;
          lvl_next       = lvl + 5'd1;
          state_next     = ST_DIV;
        end
      end
      ST_NEXTCH: begin
        if (child == 2'd3) begin
          state_next = ST_FINISH;
        end else begin
          child_next = child + 2'd1;
          state_next = ST_START;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `SQTS_ASSERT_IMP(a_step_only_in_div, (state != ST_DIV), (step == 5'd0))
  `SQTS_ASSERT_NXT(a_capture_starts, (state == ST_IDLE && in_valid), (state == ST_START))
  `SQTS_ASSERT_IMP(a_level_bounded, (state == ST_DIV), (lvl <= status.level))
endmodule

>>> hdl/sqts_dp.sv
// Datapath: capture, shared restoring divider, offsets and result register.
`timescale 1ns / 1ps
module sqts_dp #(
  parameter int LEVEL_MAX = 31
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic signed [31:0] parent_height,
  input  logic [4:0]         parent_level,
  input  logic signed [31:0] north_height,
  input  logic signed [31:0] south_height,
  input  logic signed [31:0] east_height,
  input  logic signed [31:0] west_height,
  input  logic [15:0]        rand_ne,
  input  logic [15:0]        rand_nw,
  input  logic [15:0]        rand_se,
  input  logic [15:0]        rand_sw,
  input  sqts_pkg::cmd_t     cmd,
  output sqts_pkg::status_t  status,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] ne_height,
  output logic signed [31:0] nw_height,
  output logic signed [31:0] se_height,
  output logic signed [31:0] sw_height,
  output logic [4:0]         child_level
);
  import sqts_pkg::*;

  logic [30:0] max_height;
  logic [15:0] roughness;

  logic [17:0]        mag;
  logic [17:0]        dabs [4];
  logic               dneg [4];
  logic signed [32:0] base [4];
  logic signed [31:0] off  [4];
  logic [4:0]         level;
  logic [4:0]         clevel;
  logic [17:0]        rough_eff;

  logic [17:0] rem;
  logic [30:0] sh;
  logic [17:0] divisor;

  // Capture arithmetic.
  logic [15:0]        rv [4];
  logic [17:0]        rsum;
  logic signed [19:0] dv [4];
  logic [17:0]        av [4];
  logic [17:0]        m01, m23, mall;
  logic signed [34:0] pw, nb1 [4], nb2 [4], bsum [4];
  logic [5:0]         lvl_inc;

  always_comb begin
    rv[0] = rand_ne;
    rv[1] = rand_nw;
    rv[2] = rand_se;
    rv[3] = rand_sw;
    rsum = 18'(rv[0]) + 18'(rv[1]) + 18'(rv[2]) + 18'(rv[3]);
    for (int i = 0; i < 4; i++) begin
      dv[i] = $signed({2'b00, rv[i], 2'b00}) - $signed({2'b00, rsum});
      av[i] = dv[i][19] ? 18'(-dv[i]) : dv[i][17:0];
    end
    m01  = (av[0] > av[1]) ? av[0] : av[1];
    m23  = (av[2] > av[3]) ? av[2] : av[3];
    mall = (m01 > m23) ? m01 : m23;
    pw = 35'(parent_height) <<< 1;
    nb1[0] = 35'(north_height); nb2[0] = 35'(east_height);
    nb1[1] = 35'(north_height); nb2[1] = 35'(west_height);
    nb1[2] = 35'(south_height); nb2[2] = 35'(east_height);
    nb1[3] = 35'(south_height); nb2[3] = 35'(west_height);
    for (int i = 0; i < 4; i++) begin
      bsum[i] = pw + nb1[i] + nb2[i];
    end
    lvl_inc = 6'(parent_level) + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_height <= 31'd65536;
      roughness  <= 16'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_HEIGHT: max_height <= cfg_data;
        REG_ROUGHNESS:  roughness  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mag   <= mall;
      level <= parent_level;
      for (int i = 0; i < 4; i++) begin
        dabs[i] <= av[i];
        dneg[i] <= dv[i][19];
        base[i] <= bsum[i][34:2];
      end
      if (7'(lvl_inc) > 7'(LEVEL_MAX)) clevel <= 5'(LEVEL_MAX);
      else clevel <= lvl_inc[4:0];
      rough_eff <= (roughness < 16'd256) ? 18'd256 : 18'(roughness);
    end
  end

  // Shared divider: 31 quotient bits, one per cycle.
  logic [48:0] prod;
  logic [18:0] trial;
  logic [18:0] diff;
  logic        ge;
  logic [31:0] qext;

  always_comb begin
    prod  = 49'(dabs[cmd.child]) * 49'(max_height);
    trial = {rem, sh[30]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
    qext  = {1'b0, sh};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mul) begin
      rem     <= prod[48:31];
      sh      <= prod[30:0];
      divisor <= mag;
    end else if (cmd.load_rough) begin
      rem     <= {10'd0, sh[30:23]};
      sh      <= {sh[22:0], 8'd0};
      divisor <= rough_eff;
    end else if (cmd.step) begin
      rem <= ge ? diff[17:0] : trial[17:0];
      sh  <= {sh[29:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.zero_off) begin
      off[cmd.child] <= '0;
    end else if (cmd.store) begin
      off[cmd.child] <= dneg[cmd.child] ? -$signed(qext) : $signed(qext);
    end
  end

  // Sum and saturate at the output load.
  logic signed [33:0] hsum [4];
  logic signed [31:0] hsat [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hsum[i] = 34'(base[i]) + 34'(off[i]);
      if (hsum[i][33:31] == 3'b000 || hsum[i][33:31] == 3'b111) begin
        hsat[i] = hsum[i][31:0];
      end else if (hsum[i][33]) begin
        hsat[i] = 32'sh80000000;
      end else begin
        hsat[i] = 32'sh7fffffff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ne_height   <= hsat[0];
      nw_height   <= hsat[1];
      se_height   <= hsat[2];
      sw_height   <= hsat[3];
      child_level <= clevel;
    end
  end

  assign status.mag_zero = (mag == 18'd0);
  assign status.out_free = !out_valid || !out_stall;
  assign status.level    = level;
endmodule

>>> hdl/smooth_quad_terrain_subdivide.sv
// Top level of the terrain subdivision block: sequencer plus datapath.
`timescale 1ns / 1ps
//  channel   direction  signals
//  request   in         in_valid, in_stall, parent/neighbor heights, level, samples
//  result    out        out_valid, out_stall, four child heights, child_level
//  config    in         cfg_we, cfg_index, cfg_data
//
// A request keeps the block busy from the cycle in which it is accepted to the cycle
// in which its result is loaded; the result is registered at that load and shows on
// the outputs in the cycle after it. The single shared restoring divider, one quotient
// bit per cycle over 31 bits, does the divisions for all four children in turn.
// When all samples are equal the division is skipped.
// Reset is synchronous and restores max_height and roughness.
// A finished result waits in the output register while the next request is taken;
// the load of a new result waits as long as an earlier one is stalled.
module smooth_quad_terrain_subdivide #(
  parameter int LEVEL_MAX = 31
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] parent_height,
  input  logic [4:0]         parent_level,
  input  logic signed [31:0] north_height,
  input  logic signed [31:0] south_height,
  input  logic signed [31:0] east_height,
  input  logic signed [31:0] west_height,
  input  logic [15:0]        rand_ne,
  input  logic [15:0]        rand_nw,
  input  logic [15:0]        rand_se,
  input  logic [15:0]        rand_sw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] ne_height,
  output logic signed [31:0] nw_height,
  output logic signed [31:0] se_height,
  output logic signed [31:0] sw_height,
  output logic [4:0]         child_level
);
  import sqts_pkg::*;

  // The sequencer walks the four children in turn; unless all samples are equal, each
  // child runs one scaled division by the largest deviation, then one roughness
  // division per parent level, all through the same divider.
  cmd_t    cmd;
  status_t status;

  sqts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sqts_dp #(
    .LEVEL_MAX (LEVEL_MAX)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .parent_height (parent_height),
    .parent_level  (parent_level),
    .north_height  (north_height),
    .south_height  (south_height),
    .east_height   (east_height),
    .west_height   (west_height),
    .rand_ne       (rand_ne),
    .rand_nw       (rand_nw),
    .rand_se       (rand_se),
    .rand_sw       (rand_sw),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .ne_height     (ne_height),
    .nw_height     (nw_height),
    .se_height     (se_height),
    .sw_height     (sw_height),
    .child_level   (child_level)
  );
endmodule
